>>> rtl/core/rlc_pkg.sv
// Shared types and constants for the three-rotor letter cipher.
// Used by every module of the block but rlc_fifo; depends on nothing.
package rlc_pkg;

  localparam int CHAR_W     = 8;
  localparam int POS_W      = 5;
  localparam int SEL_W      = 2;
  localparam int NUM_ROTORS = 3;

  localparam logic [CHAR_W-1:0] LOWER_BASE = 8'h61;
  localparam logic [CHAR_W-1:0] UPPER_BASE = 8'h41;

  // Item mode as it arrives on the input channel.
  typedef enum logic {
    MODE_TRANSLATE = 1'b0,
    MODE_LOAD      = 1'b1
  } mode_t;

  // Classified operation handed from the front to the back.
  typedef enum logic [1:0] {
    OP_PASS,
    OP_LETTER,
    OP_LOAD
  } op_kind_t;

  typedef struct packed {
    op_kind_t                             kind;
    logic                                 lower;
    logic [CHAR_W-1:0]                    chr;
    logic [POS_W-1:0]                     pos;
    logic [NUM_ROTORS-1:0][POS_W-1:0]     off;
    logic [SEL_W-1:0]                     sel;
    logic [POS_W-1:0]                     idx;
    logic [POS_W-1:0]                     val;
  } rlc_op_t;

  localparam int OP_W = $bits(rlc_op_t);

  // Status of the back part, watched at the top level.
  typedef struct packed {
    logic mid_pop;
    logic out_push;
    logic out_full;
  } rlc_back_stat_t;

endpackage

>>> rtl/core/rlc_fifo.sv
// Small register-based FIFO with a count output.
// Generic; used for the operation queue and the result queue. No dependencies.
module rlc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Handshake qualification and pointer update.
  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = mem_r[rd_ptr_r];

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage is written on every push transfer.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/core/rlc_front.sv
// Front part: accepts input items, classifies them and assigns rotor offsets.
// Depends on rlc_pkg; feeds the operation queue.
module rlc_front import rlc_pkg::*; #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_mode,
  input  logic [CHAR_W-1:0] in_char_in,
  input  logic [SEL_W-1:0]  in_rotor_select,
  input  logic [POS_W-1:0]  in_entry_index,
  input  logic [POS_W-1:0]  in_entry_value,
  input  logic              q_full,
  output logic              q_push,
  output rlc_op_t           q_data
);

  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(ALPHABET_SIZE - 1);
  localparam logic [CHAR_W:0]   LO_FIRST  = {1'b0, LOWER_BASE};
  localparam logic [CHAR_W:0]   LO_END    = LO_FIRST + (CHAR_W + 1)'(ALPHABET_SIZE);
  localparam logic [CHAR_W:0]   UP_FIRST  = {1'b0, UPPER_BASE};
  localparam logic [CHAR_W:0]   UP_END    = UP_FIRST + (CHAR_W + 1)'(ALPHABET_SIZE);
  localparam logic [POS_W:0]    IDX_LIMIT = (POS_W + 1)'(ALPHABET_SIZE);

  logic [NUM_ROTORS-1:0][POS_W-1:0] off_r, off_nxt;
  logic [POS_W-1:0]                 cnt_lo_r, cnt_lo_nxt;
  logic [POS_W-1:0]                 cnt_hi_r, cnt_hi_nxt;
  logic [POS_W-1:0]                 mod_lut [2**POS_W];
  logic                             accept, is_lower, is_upper, is_letter, load_ok, step;
  logic [CHAR_W:0]                  c_ext;

  // Constant table of stored values reduced modulo the alphabet size.
  for (genvar g = 0; g < 2**POS_W; g++) begin : g_mod
    localparam int unsigned MOD_VAL = g % ALPHABET_SIZE;
    assign mod_lut[g] = POS_W'(MOD_VAL);
  end

  function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] v);
    return (v == LAST_POS) ? '0 : v + 1'b1;
  endfunction

  // Classification of the item at the input ports.
  always_comb begin
    accept    = in_push && !q_full;
    c_ext     = {1'b0, in_char_in};
    is_lower  = (c_ext >= LO_FIRST) && (c_ext < LO_END);
    is_upper  = (c_ext >= UP_FIRST) && (c_ext < UP_END);
    is_letter = is_lower || is_upper;
    load_ok   = (in_rotor_select < SEL_W'(NUM_ROTORS)) &&
                ({1'b0, in_entry_index} < IDX_LIMIT);

    q_data       = '0;
    q_data.chr   = in_char_in;
    q_data.lower = is_lower;
    q_data.pos   = is_lower ? POS_W'(in_char_in - LOWER_BASE)
                            : POS_W'(in_char_in - UPPER_BASE);
    q_data.off   = off_r;
    q_data.sel   = in_rotor_select;
    q_data.idx   = in_entry_index;
    q_data.val   = mod_lut[in_entry_value];
    if (in_mode == MODE_LOAD) begin
      q_data.kind = OP_LOAD;
    end else if (is_letter) begin
      q_data.kind = OP_LETTER;
    end else begin
      q_data.kind = OP_PASS;
    end

    // Loads that address no table entry are dropped here.
    q_push = accept && ((in_mode == MODE_TRANSLATE) || load_ok);
    step   = accept && (in_mode == MODE_TRANSLATE) && is_letter;
  end

  // Rotor stepping after each translated letter.
  always_comb begin
    off_nxt    = off_r;
    cnt_lo_nxt = cnt_lo_r;
    cnt_hi_nxt = cnt_hi_r;
    if (step) begin
      off_nxt[0] = advance(off_r[0]);
      cnt_lo_nxt = advance(cnt_lo_r);
      if (cnt_lo_r == LAST_POS) begin
        off_nxt[1] = advance(off_r[1]);
        cnt_hi_nxt = advance(cnt_hi_r);
        if (cnt_hi_r == LAST_POS) begin
          off_nxt[2] = advance(off_r[2]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r    <= '0;
      cnt_lo_r <= '0;
      cnt_hi_r <= '0;
    end else begin
      off_r    <= off_nxt;
      cnt_lo_r <= cnt_lo_nxt;
      cnt_hi_r <= cnt_hi_nxt;
    end
  end

endmodule

>>> rtl/core/rlc_rotor_stage.sv
// One rotor stage: holds one rotor table, applies loads and substitutes letters.
// Depends on rlc_pkg; instantiated three times by rlc_back.
module rlc_rotor_stage import rlc_pkg::*; #(
  parameter int ALPHABET_SIZE = 26,
  parameter int ROTOR         = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  rlc_op_t in_op,
  output logic    out_valid,
  output rlc_op_t out_op
);

  localparam int             IW    = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam logic [POS_W:0] LIMIT = (POS_W + 1)'(ALPHABET_SIZE);

  logic [POS_W-1:0] tbl_r [ALPHABET_SIZE];
  logic [POS_W:0]   sum, idx;
  logic             wr_en;
  logic             valid_r;
  rlc_op_t          op_r, op_nxt;

  // Rotated lookup: index is position plus offset, reduced once.
  always_comb begin
    sum    = {1'b0, in_op.pos} + {1'b0, in_op.off[ROTOR]};
    idx    = (sum >= LIMIT) ? sum - LIMIT : sum;
    wr_en  = in_valid && (in_op.kind == OP_LOAD) && (in_op.sel == SEL_W'(ROTOR));
    op_nxt = in_op;
    if (in_op.kind == OP_LETTER) begin
      op_nxt.pos = tbl_r[idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_r[in_op.idx[IW-1:0]] <= in_op.val;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

  assign out_valid = valid_r;
  assign out_op    = op_r;

endmodule

>>> rtl/core/rlc_back.sv
// Back part: three rotor stages in a row and the result queue, with credit flow.
// Depends on rlc_pkg, rlc_rotor_stage and rlc_fifo.
module rlc_back import rlc_pkg::*; #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              mid_empty,
  input  rlc_op_t           mid_data,
  output logic              mid_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output logic [CHAR_W-1:0] out_char,
  output rlc_back_stat_t    stat
);

  localparam int OUT_DEPTH = 8;
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  logic [NUM_ROTORS:0] st_valid;
  rlc_op_t             st_op [NUM_ROTORS+1];
  logic [1:0]          inflight;
  logic [OCW-1:0]      out_count;
  logic                out_full, out_push;
  logic [CHAR_W-1:0]   res_char;
  rlc_op_t             last_op;

  // Credit check: every result already in the stages has a queue slot.
  always_comb begin
    inflight = '0;
    for (int k = 1; k <= NUM_ROTORS; k++) begin
      if (st_valid[k] && (st_op[k].kind != OP_LOAD)) begin
        inflight = inflight + 1'b1;
      end
    end
    mid_pop = !mid_empty &&
              (({1'b0, out_count} + (OCW + 1)'(inflight)) < (OCW + 1)'(OUT_DEPTH));
  end

  assign st_valid[0] = mid_pop;
  assign st_op[0]    = mid_data;

  for (genvar r = 0; r < NUM_ROTORS; r++) begin : g_rotor
    rlc_rotor_stage #(
      .ALPHABET_SIZE(ALPHABET_SIZE),
      .ROTOR        (r)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (st_valid[r]),
      .in_op    (st_op[r]),
      .out_valid(st_valid[r+1]),
      .out_op   (st_op[r+1])
    );
  end

  // Result formation after the last rotor.
  always_comb begin
    last_op  = st_op[NUM_ROTORS];
    out_push = st_valid[NUM_ROTORS] && (last_op.kind != OP_LOAD);
    if (last_op.kind == OP_LETTER) begin
      res_char = (last_op.lower ? LOWER_BASE : UPPER_BASE) + CHAR_W'(last_op.pos);
    end else begin
      res_char = last_op.chr;
    end
  end

  rlc_fifo #(
    .WIDTH(CHAR_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (out_push),
    .wr_data(res_char),
    .full   (out_full),
    .pop    (out_pop),
    .rd_data(out_char),
    .empty  (out_empty),
    .count  (out_count)
  );

  assign stat.mid_pop  = mid_pop;
  assign stat.out_push = out_push;
  assign stat.out_full = out_full;

endmodule

>>> rtl/core/three_rotor_letter_cipher.sv
// Three-rotor letter cipher, top level. Depends on rlc_pkg, rlc_front, rlc_fifo, rlc_back.
// Throughput: one item per cycle while the result queue has room; the three rotor lookups are
// pipelined one per stage. A result reaches the out_ ports through the operation queue, the
// three rotor stage registers and the result queue.
// Reset (rst_n low, synchronous): offsets, letter count and queues clear; the
// rotor tables keep their contents and are undefined until loaded.
module three_rotor_letter_cipher import rlc_pkg::*; #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_mode,
  input  logic [CHAR_W-1:0] in_char_in,
  input  logic [SEL_W-1:0]  in_rotor_select,
  input  logic [POS_W-1:0]  in_entry_index,
  input  logic [POS_W-1:0]  in_entry_value,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [CHAR_W-1:0] out_char_out
);

  localparam int MID_DEPTH = 2;
  localparam int MCW       = $clog2(MID_DEPTH + 1);

  logic           mid_push, mid_full, mid_empty, mid_pop;
  rlc_op_t        front_op, mid_op;
  logic [MCW-1:0] mid_count;
  rlc_back_stat_t back_stat;

  // Front: classification and rotor stepping.
  rlc_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_mode        (in_mode),
    .in_char_in     (in_char_in),
    .in_rotor_select(in_rotor_select),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .q_full         (mid_full),
    .q_push         (mid_push),
    .q_data         (front_op)
  );

  assign in_full = mid_full;

  // Operation queue between front and back.
  rlc_fifo #(
    .WIDTH(OP_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (mid_push),
    .wr_data(front_op),
    .full   (mid_full),
    .pop    (mid_pop),
    .rd_data(mid_op),
    .empty  (mid_empty),
    .count  (mid_count)
  );

  // Back: rotor substitution and result queue.
  rlc_back #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mid_empty(mid_empty),
    .mid_data (mid_op),
    .mid_pop  (mid_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_char (out_char_out),
    .stat     (back_stat)
  );

`ifndef NO_ASSERTIONS
  // The back only takes operations that are present in the queue.
  a_mid_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.mid_pop |-> !mid_empty)
    else $error("operation queue popped while empty");

  // Credit flow must keep the result queue from overflowing.
  a_out_credit: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.out_push |-> !back_stat.out_full)
    else $error("result dropped at a full result queue");

  // The operation queue never holds more than its depth.
  a_mid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mid_count <= MCW'(MID_DEPTH))
    else $error("operation queue count out of range");

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (out_empty && mid_empty))
    else $error("queue not empty after reset");
`endif

endmodule
